[rtl/crcr_pkg.sv]
// Shared widths, constants, band codes and control structs of the count rate color ramp.
`default_nettype none

package crcr_pkg;

  localparam int RATE_W      = 16;
  localparam int TEMP_W      = 12;
  localparam int STAT_TEMP_W = 15;
  localparam int LEVEL_W     = 8;
  localparam int BW_W        = 10;
  localparam int NUM_W       = 11;
  localparam int REM_W       = 11;
  localparam int DIVIDEND_W  = 17;
  localparam int MULT_W      = 13;
  localparam int PCT_W       = 7;
  localparam int DIV_STEPS   = DIVIDEND_W;
  localparam int STEP_CNT_W  = 5;
  localparam int BAND_W      = 3;

  localparam logic [BW_W-1:0]               BW_RESET       = 10'd10;
  localparam logic [RATE_W-1:0]             RATE_LOW_RESET = 16'd10000;
  localparam logic signed [STAT_TEMP_W-1:0] TEMP_LOW_RESET = 15'sd10000;
  localparam logic [LEVEL_W-1:0]            DIM_LEVEL      = 8'd64;
  localparam logic [LEVEL_W-1:0]            FULL_LEVEL     = 8'd255;
  localparam logic [NUM_W-1:0]              PCT_SCALE      = 11'd100;

  localparam logic [BAND_W-1:0] BAND_1   = 3'd0;
  localparam logic [BAND_W-1:0] BAND_2   = 3'd1;
  localparam logic [BAND_W-1:0] BAND_3   = 3'd2;
  localparam logic [BAND_W-1:0] BAND_4   = 3'd3;
  localparam logic [BAND_W-1:0] BAND_5   = 3'd4;
  localparam logic [BAND_W-1:0] BAND_TOP = 3'd5;

  typedef struct packed {
    logic accept;
    logic classify;
    logic load_pct;
    logic load_scale;
    logic div_step;
    logic finish;
  } crcr_cmd_t;

  typedef struct packed {
    logic out_busy;
  } crcr_status_t;

endpackage

`default_nettype wire

[rtl/count_rate_color_ramp.sv]
// Top level of the count rate color ramp: controller, datapath and stream ports.
//
//   channel   direction  handshake              payload
//   in_       slave      in_tvalid / in_tready  count_rate, temperature, operation
//   out_      master     out_tvalid/out_tready  colors, brightness, statistics
//   cfg_      slave      cfg_valid / cfg_ready  band_width
//
// Each request runs from acceptance through classify, then two 17-step passes through
// the single shared restoring divider, each after a load of its operands, and then a
// write of the output register that waits while the output holds an untaken result.
// Reset is synchronous and active low; it restores band_width to 10 and the statistics.
// A result waiting at the output holds the finished request; a new request is taken
// as soon as the controller is idle, even while the previous result is not yet taken.
`default_nettype none

module count_rate_color_ramp (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] count_rate, [27:16] temperature, zero pad
  input  wire logic        in_tuser,   // [0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // [7:0] red_level, [15:8] green_level,
                                       // [23:16] blue_level, [31:24] brightness,
                                       // [47:32] rate_minimum, [63:48] rate_maximum,
                                       // [78:64] temp_minimum, [93:79] temp_maximum, pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [9:0]  cfg_data
);

  crcr_pkg::crcr_cmd_t    cmd;
  crcr_pkg::crcr_status_t status;

  logic [crcr_pkg::LEVEL_W-1:0]            red_level, green_level, blue_level, brightness;
  logic [crcr_pkg::RATE_W-1:0]             rate_minimum, rate_maximum;
  logic signed [crcr_pkg::STAT_TEMP_W-1:0] temp_minimum, temp_maximum;

  assign cfg_ready = 1'b1;

  crcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  crcr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_op        (in_tuser),
    .in_count     (in_tdata[15:0]),
    .in_temp      (in_tdata[27:16]),
    .cfg_write    (cfg_valid & cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .red_level    (red_level),
    .green_level  (green_level),
    .blue_level   (blue_level),
    .brightness   (brightness),
    .rate_minimum (rate_minimum),
    .rate_maximum (rate_maximum),
    .temp_minimum (temp_minimum),
    .temp_maximum (temp_maximum)
  );

  assign out_tdata = {2'b00, temp_maximum, temp_minimum, rate_maximum, rate_minimum,
                      brightness, blue_level, green_level, red_level};

endmodule

`default_nettype wire

[rtl/crcr_div.sv]
// Restoring divider that produces one quotient bit per cycle while step is high.
`default_nettype none

module crcr_div (
  input  wire logic                              clk,
  input  wire logic                              load,
  input  wire logic                              step,
  input  wire logic [crcr_pkg::DIVIDEND_W-1:0]   dividend,
  input  wire logic [crcr_pkg::NUM_W-1:0]        divisor,
  output logic      [crcr_pkg::DIVIDEND_W-1:0]   quotient
);

  logic [crcr_pkg::REM_W-1:0]      rem_r, rem_nxt;
  logic [crcr_pkg::DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [crcr_pkg::NUM_W-1:0]      den_r;
  logic [crcr_pkg::REM_W:0]        trial;
  logic                            fits;

  always_comb begin
    trial = {rem_r, quo_r[crcr_pkg::DIVIDEND_W-1]};
    fits  = trial >= {1'b0, den_r};
    if (fits) begin
      rem_nxt = crcr_pkg::REM_W'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[crcr_pkg::REM_W-1:0];
    end
    quo_nxt = {quo_r[crcr_pkg::DIVIDEND_W-2:0], fits};
  end

  // The dividend is shifted out of the top of quo_r while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;

endmodule

`default_nettype wire

[rtl/crcr_ctrl.sv]
// Controller state machine that sequences classify, the two divisions and the result write.
`default_nettype none

module crcr_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire crcr_pkg::crcr_status_t status,
  output crcr_pkg::crcr_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_CLASS      = 3'd1;
  localparam logic [2:0] S_LOAD_PCT   = 3'd2;
  localparam logic [2:0] S_DIV_PCT    = 3'd3;
  localparam logic [2:0] S_LOAD_SCALE = 3'd4;
  localparam logic [2:0] S_DIV_SCALE  = 3'd5;
  localparam logic [2:0] S_FIN        = 3'd6;

  localparam logic [crcr_pkg::STEP_CNT_W-1:0] LAST_STEP =
    crcr_pkg::STEP_CNT_W'(crcr_pkg::DIV_STEPS - 1);

  logic [2:0]                        state_r, state_nxt;
  logic [crcr_pkg::STEP_CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        state_nxt    = S_LOAD_PCT;
      end
      S_LOAD_PCT: begin
        cmd.load_pct = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV_PCT;
      end
      S_DIV_PCT: begin
        cmd.div_step = 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_LOAD_SCALE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_LOAD_SCALE: begin
        cmd.load_scale = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = S_DIV_SCALE;
      end
      S_DIV_SCALE: begin
        cmd.div_step = 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        // Hold the finished item until the output register can take it.
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/crcr_dp.sv]
// Datapath: band register, statistics, band classification, divider operands and result register.
`default_nettype none

module crcr_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire crcr_pkg::crcr_cmd_t                   cmd,
  output crcr_pkg::crcr_status_t                     status,
  input  wire logic                                  in_op,
  input  wire logic [crcr_pkg::RATE_W-1:0]           in_count,
  input  wire logic signed [crcr_pkg::TEMP_W-1:0]    in_temp,
  input  wire logic                                  cfg_write,
  input  wire logic [crcr_pkg::BW_W-1:0]             cfg_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [crcr_pkg::LEVEL_W-1:0]               red_level,
  output logic [crcr_pkg::LEVEL_W-1:0]               green_level,
  output logic [crcr_pkg::LEVEL_W-1:0]               blue_level,
  output logic [crcr_pkg::LEVEL_W-1:0]               brightness,
  output logic [crcr_pkg::RATE_W-1:0]                rate_minimum,
  output logic [crcr_pkg::RATE_W-1:0]                rate_maximum,
  output logic signed [crcr_pkg::STAT_TEMP_W-1:0]    temp_minimum,
  output logic signed [crcr_pkg::STAT_TEMP_W-1:0]    temp_maximum
);

  localparam int CMP_W = crcr_pkg::RATE_W + 1;

  logic [crcr_pkg::BW_W-1:0]               band_width_r;
  logic [crcr_pkg::RATE_W-1:0]             low_rate_r, high_rate_r;
  logic signed [crcr_pkg::STAT_TEMP_W-1:0] low_temp_r, high_temp_r;
  logic [crcr_pkg::RATE_W-1:0]             count_r;
  logic [crcr_pkg::BAND_W-1:0]             band_r, band_nxt;
  logic [crcr_pkg::NUM_W-1:0]              num_r, num_nxt;
  logic [crcr_pkg::NUM_W-1:0]              den_r, den_nxt;
  logic                                    out_valid_r;
  logic [crcr_pkg::LEVEL_W-1:0]            red_r, green_r, blue_r, bright_r;
  logic [crcr_pkg::LEVEL_W-1:0]            red_nxt, green_nxt, blue_nxt, bright_nxt;

  logic [crcr_pkg::BW_W-1:0]               w_eff;
  logic [crcr_pkg::MULT_W-1:0]             m1, m2, m3, m4, m5;
  logic [CMP_W-1:0]                        c_ext, base;
  logic signed [crcr_pkg::STAT_TEMP_W-1:0] temp_ext;

  logic                                    div_load;
  logic [crcr_pkg::DIVIDEND_W-1:0]         div_dividend, div_quotient;
  logic [crcr_pkg::NUM_W-1:0]              div_divisor;
  logic [crcr_pkg::DIVIDEND_W:0]           pct_prod;
  logic [crcr_pkg::DIVIDEND_W-1:0]         scale_prod;
  logic [crcr_pkg::LEVEL_W-1:0]            s;

  assign temp_ext = crcr_pkg::STAT_TEMP_W'(in_temp);

  // Band classification: the highest band that contains the count wins.
  always_comb begin
    w_eff = (band_width_r == '0) ? crcr_pkg::BW_W'(1) : band_width_r;
    m1    = crcr_pkg::MULT_W'(w_eff);
    m2    = m1 << 1;
    m3    = m1 + m2;
    m4    = m1 << 2;
    m5    = m4 + m1;
    c_ext = CMP_W'(count_r);
    den_nxt = crcr_pkg::NUM_W'(w_eff) + 1'b1;
    base  = '0;
    if (c_ext > CMP_W'(m5)) begin
      band_nxt = crcr_pkg::BAND_TOP;
      base     = CMP_W'(m5);
    end else if (c_ext >= CMP_W'(m4)) begin
      band_nxt = crcr_pkg::BAND_5;
      base     = CMP_W'(m4);
    end else if (c_ext >= CMP_W'(m3)) begin
      band_nxt = crcr_pkg::BAND_4;
      base     = CMP_W'(m3);
    end else if (c_ext >= CMP_W'(m2)) begin
      band_nxt = crcr_pkg::BAND_3;
      base     = CMP_W'(m2);
    end else if (c_ext >= CMP_W'(m1)) begin
      band_nxt = crcr_pkg::BAND_2;
      base     = CMP_W'(m1);
    end else begin
      band_nxt = crcr_pkg::BAND_1;
      den_nxt  = crcr_pkg::NUM_W'(w_eff);
    end
    // Upper bands measure from one below their lower edge; the first band from zero.
    if (band_nxt == crcr_pkg::BAND_1) begin
      num_nxt = crcr_pkg::NUM_W'(count_r);
    end else begin
      num_nxt = crcr_pkg::NUM_W'(c_ext - base + 1'b1);
    end
  end

  // First pass gives the percent within the band, second pass scales it to 0..255.
  always_comb begin
    pct_prod     = (crcr_pkg::DIVIDEND_W + 1)'(num_r) * (crcr_pkg::DIVIDEND_W + 1)'(100);
    scale_prod   = crcr_pkg::DIVIDEND_W'(div_quotient[crcr_pkg::PCT_W-1:0]) *
                   crcr_pkg::DIVIDEND_W'(255);
    div_load     = cmd.load_pct | cmd.load_scale;
    div_dividend = cmd.load_scale ? scale_prod : pct_prod[crcr_pkg::DIVIDEND_W-1:0];
    div_divisor  = cmd.load_scale ? crcr_pkg::PCT_SCALE : den_r;
  end

  crcr_div u_div (
    .clk      (clk),
    .load     (div_load),
    .step     (cmd.div_step),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient)
  );

  always_comb begin
    s          = div_quotient[crcr_pkg::LEVEL_W-1:0];
    bright_nxt = crcr_pkg::DIM_LEVEL;
    red_nxt    = '0;
    green_nxt  = '0;
    blue_nxt   = '0;
    case (band_r)
      crcr_pkg::BAND_1: begin
        red_nxt   = 8'd255 - s;
        green_nxt = 8'd255;
      end
      crcr_pkg::BAND_2: begin
        green_nxt = 8'd255;
        blue_nxt  = s;
      end
      crcr_pkg::BAND_3: begin
        green_nxt = 8'd255 - s;
        blue_nxt  = 8'd255;
      end
      crcr_pkg::BAND_4: begin
        red_nxt  = s;
        blue_nxt = 8'd255;
      end
      crcr_pkg::BAND_5: begin
        red_nxt  = 8'd255;
        blue_nxt = 8'd255 - s;
      end
      crcr_pkg::BAND_TOP: begin
        red_nxt    = 8'd255;
        bright_nxt = crcr_pkg::FULL_LEVEL;
      end
      default: begin
        red_nxt = 8'd255;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_width_r <= crcr_pkg::BW_RESET;
      low_rate_r   <= crcr_pkg::RATE_LOW_RESET;
      high_rate_r  <= '0;
      low_temp_r   <= crcr_pkg::TEMP_LOW_RESET;
      high_temp_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_write) begin
        band_width_r <= cfg_data;
      end
      if (cmd.accept) begin
        if (in_op) begin
          low_rate_r  <= crcr_pkg::RATE_LOW_RESET;
          high_rate_r <= '0;
          low_temp_r  <= crcr_pkg::TEMP_LOW_RESET;
          high_temp_r <= '0;
        end else begin
          if (in_count < low_rate_r && in_count != '0) begin
            low_rate_r <= in_count;
          end
          if (in_count > high_rate_r) begin
            high_rate_r <= in_count;
          end
          if (temp_ext < low_temp_r && temp_ext > 0) begin
            low_temp_r <= temp_ext;
          end
          if (temp_ext > high_temp_r) begin
            high_temp_r <= temp_ext;
          end
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      count_r <= in_count;
    end
    if (cmd.classify) begin
      band_r <= band_nxt;
      num_r  <= num_nxt;
      den_r  <= den_nxt;
    end
    if (cmd.finish) begin
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      blue_r   <= blue_nxt;
      bright_r <= bright_nxt;
    end
  end

  // Statistics cannot change between accept and finish, so they are read straight out.
  logic [crcr_pkg::RATE_W-1:0]             rmin_r, rmax_r;
  logic signed [crcr_pkg::STAT_TEMP_W-1:0] tmin_r, tmax_r;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rmin_r <= low_rate_r;
      rmax_r <= high_rate_r;
      tmin_r <= low_temp_r;
      tmax_r <= high_temp_r;
    end
  end

  assign status.out_busy = out_valid_r & ~out_ready;
  assign out_valid       = out_valid_r;
  assign red_level       = red_r;
  assign green_level     = green_r;
  assign blue_level      = blue_r;
  assign brightness      = bright_r;
  assign rate_minimum    = rmin_r;
  assign rate_maximum    = rmax_r;
  assign temp_minimum    = tmin_r;
  assign temp_maximum    = tmax_r;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the count rate color ramp: random stream traffic checked against a predictor.
`timescale 1ns / 1ps

module testbench;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;
  localparam int   HALF_PERIOD = 4;
  localparam int   RESET_CYCLES = 7;
  localparam int   STALL_LIMIT = 2000;
  localparam int   SETTLE_CYCLES = 60;
  localparam int   PHASES = 10;
  localparam int   ITEMS_PER_PHASE = 185;

  typedef struct {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         bright;
    logic [15:0]        rate_min;
    logic [15:0]        rate_max;
    logic signed [14:0] temp_min;
    logic signed [14:0] temp_max;
  } led_colors_t;

  class color_ramp_book;
    logic [9:0]  band_width;
    int          low_rate;
    int          high_rate;
    int          low_temp;
    int          high_temp;
    led_colors_t due_colors[$];
    int unsigned faults;

    function new();
      band_width = crcr_pkg::BW_RESET;
      clear_stats();
      faults = 0;
    endfunction

    function void clear_stats();
      low_rate  = crcr_pkg::RATE_LOW_RESET;
      high_rate = 0;
      low_temp  = crcr_pkg::TEMP_LOW_RESET;
      high_temp = 0;
    endfunction

    // Works out the color and statistics that one accepted request must produce.
    function void take_sample(logic op, logic [15:0] rate, logic signed [11:0] temp);
      led_colors_t e;
      longint c, w, p, red, grn, blu;
      int t;
      c = rate;
      t = temp;
      w = (band_width == 0) ? 1 : band_width;
      if (op == OP_CLEAR) begin
        clear_stats();
      end else begin
        if (c < low_rate && c > 0) low_rate = int'(c);
        if (c > high_rate) high_rate = int'(c);
        if (t < low_temp && t > 0) low_temp = t;
        if (t > high_temp) high_temp = t;
      end
      red = 128;
      grn = 128;
      blu = 128;
      // Bands are evaluated in order so that the upper band wins on a shared edge.
      if (c <= w) begin
        p = c * 100 / w;
        red = 255 - p * 255 / 100; grn = 255; blu = 0;
      end
      if (c <= 2 * w && c > w - 1) begin
        p = (c - (w - 1)) * 100 / (w + 1);
        red = 0; grn = 255; blu = p * 255 / 100;
      end
      if (c <= 3 * w && c > 2 * w - 1) begin
        p = (c - (2 * w - 1)) * 100 / (w + 1);
        red = 0; grn = 255 - p * 255 / 100; blu = 255;
      end
      if (c <= 4 * w && c > 3 * w - 1) begin
        p = (c - (3 * w - 1)) * 100 / (w + 1);
        red = p * 255 / 100; grn = 0; blu = 255;
      end
      if (c > 4 * w - 1) begin
        p = (c - (4 * w - 1)) * 100 / (w + 1);
        red = 255; grn = 0; blu = 255 - p * 255 / 100;
        if (blu < 0) blu = 0;
      end
      if (c > 5 * w) begin
        red = 255; grn = 0; blu = 0;
        e.bright = crcr_pkg::FULL_LEVEL;
      end else begin
        e.bright = crcr_pkg::DIM_LEVEL;
      end
      e.red      = red[7:0];
      e.green    = grn[7:0];
      e.blue     = blu[7:0];
      e.rate_min = low_rate[15:0];
      e.rate_max = high_rate[15:0];
      e.temp_min = low_temp[14:0];
      e.temp_max = high_temp[14:0];
      due_colors.push_back(e);
    endfunction

    function void match(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        faults++;
      end
    endfunction

    function void check_colors(logic [95:0] data);
      led_colors_t e;
      if (due_colors.size() == 0) begin
        $error("result arrived with no request outstanding");
        faults++;
        return;
      end
      e = due_colors.pop_front();
      match("red_level", e.red, data[7:0]);
      match("green_level", e.green, data[15:8]);
      match("blue_level", e.blue, data[23:16]);
      match("brightness", e.bright, data[31:24]);
      match("rate_minimum", e.rate_min, data[47:32]);
      match("rate_maximum", e.rate_max, data[63:48]);
      match("temp_minimum", e.temp_min, $signed(data[78:64]));
      match("temp_maximum", e.temp_max, $signed(data[93:79]));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [9:0]  cfg_data;

  logic        steady;
  int unsigned stall_cycles;
  color_ramp_book ramp_book;

  count_rate_color_ramp dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ramp_book.check_colors(out_tdata);
  end

  // Ends the run if the block stops moving requests in every channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input logic op, input logic [15:0] rate,
                           input logic signed [11:0] temp);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, temp, rate};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    ramp_book.take_sample(op, rate, temp);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (ramp_book.due_colors.size() != 0) @(posedge clk);
  endtask

  task automatic write_band_width(input logic [9:0] width);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= width;
    do @(posedge clk); while (!cfg_ready);
    ramp_book.band_width = width;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly counts around the five bands, with edges and the full range mixed in.
  function automatic logic [15:0] pick_rate(int width);
    int w;
    int c;
    w = (width == 0) ? 1 : width;
    case ($urandom_range(9))
      0: c = $urandom_range(65535);
      1, 2: c = $urandom_range(5) * w + $urandom_range(2) - 1;
      default: c = $urandom_range(6 * w + 2);
    endcase
    if (c < 0) c = 0;
    if (c > 65535) c = 65535;
    return c[15:0];
  endfunction

  initial begin
    int phase;
    int width;
    logic [11:0] temp;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_SAMPLE;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    steady     = 1'b0;
    stall_cycles = 0;
    ramp_book  = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Band edges at the reset band width, field extremes and clears.
    send_item(OP_SAMPLE, 16'd0, 12'sd0);
    send_item(OP_SAMPLE, 16'd1, 12'sd1);
    send_item(OP_SAMPLE, 16'd9, -12'sd1);
    send_item(OP_SAMPLE, 16'd10, 12'sd2047);
    send_item(OP_SAMPLE, 16'd11, -12'sd2048);
    send_item(OP_SAMPLE, 16'd19, 12'sd5);
    send_item(OP_SAMPLE, 16'd20, 12'sd3);
    send_item(OP_SAMPLE, 16'd21, 12'sd100);
    send_item(OP_SAMPLE, 16'd29, 12'sd0);
    send_item(OP_SAMPLE, 16'd30, 12'sd7);
    send_item(OP_SAMPLE, 16'd31, -12'sd7);
    send_item(OP_SAMPLE, 16'd39, 12'sd2);
    send_item(OP_SAMPLE, 16'd40, 12'sd40);
    send_item(OP_SAMPLE, 16'd41, 12'sd41);
    send_item(OP_SAMPLE, 16'd49, 12'sd49);
    send_item(OP_SAMPLE, 16'd50, 12'sd50);
    send_item(OP_SAMPLE, 16'd51, 12'sd51);
    send_item(OP_SAMPLE, 16'd65535, 12'sd2047);
    send_item(OP_CLEAR, 16'd25, -12'sd5);
    send_item(OP_SAMPLE, 16'd10001, 12'sd9);
    send_item(OP_SAMPLE, 16'd12, -12'sd2048);
    send_item(OP_CLEAR, 16'd0, 12'sd0);
    send_item(OP_SAMPLE, 16'd5, 12'sd1);

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: width = 1;
        1: width = 0;
        2: width = 1000;
        3: width = 1023;
        4: width = 3;
        default: width = $urandom_range(1, 1000);
      endcase
      write_band_width(width[9:0]);
      steady = (phase == 2);
      repeat (ITEMS_PER_PHASE) begin
        temp = 12'(($urandom_range(3) == 0) ? $urandom_range(4) - 1 : $urandom_range(4095));
        send_item(($urandom_range(99) < 5) ? OP_CLEAR : OP_SAMPLE, pick_rate(width), temp);
      end
    end
    steady = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ramp_book.due_colors.size() != 0) begin
      $error("%0d expected results never arrived", ramp_book.due_colors.size());
      ramp_book.faults++;
    end
    if (ramp_book.faults == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[count_rate_color_ramp.f]
rtl/crcr_pkg.sv
rtl/crcr_div.sv
rtl/crcr_ctrl.sv
rtl/crcr_dp.sv
rtl/count_rate_color_ramp.sv
tb/testbench.sv
